@@ rtl/core/ardt_pkg.sv @@
// Shared types and codes for the address range dispatch table.
// Transaction structs, opcode and status codes, table command struct.
// No dependencies.
`default_nettype none

package ardt_pkg;

  // Field widths of the transactions
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TARGET_W = 4;
  localparam int unsigned SIZE_W   = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 3;

  // Data returned by a read that hits no region
  localparam logic [DATA_W-1:0] MISS_DATA = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_READ       = 2'd2,
    OP_WRITE      = 2'd3
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_CONFLICT  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_UNMAPPED  = 3'd5
  } status_e_t;

  typedef struct packed {
    op_e_t               opcode;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   limit_address;
    logic [ADDR_W-1:0]   region_offset;
    logic [TARGET_W-1:0] target_id;
    logic [SIZE_W-1:0]   access_size;
    logic [DATA_W-1:0]   write_data;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TARGET_W-1:0] routed_target;
    logic [ADDR_W-1:0]   routed_address;
    logic [SIZE_W-1:0]   routed_size;
    logic [DATA_W-1:0]   routed_data;
    logic                routed_is_write;
  } out_item_t;

  // Table update request, applied at the clock edge the transaction retires
  typedef struct packed {
    logic insert;
    logic remove;
  } tbl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/ardt_floor.sv @@
// Floor search: finds the valid entry with the greatest begin not above a key.
// Balanced compare tree, lower index wins on equal begins.
// Depends on nothing beyond its parameters.
`default_nettype none

module ardt_floor #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned EW      = 32
) (
  input  wire logic [ENTRIES-1:0] valid_i,
  input  wire logic [EW-1:0]      begin_i [ENTRIES],
  input  wire logic [EW-1:0]      key_i,
  output logic                    found_o,
  output logic [$clog2(ENTRIES)-1:0] idx_o
);

  localparam int unsigned LV    = $clog2(ENTRIES);
  localparam int unsigned LEAFS = 1 << LV;
  localparam int unsigned NODES = 2 * LEAFS - 1;

  typedef struct packed {
    logic          found;
    logic [EW-1:0] bgn;
    logic [LV-1:0] idx;
  } node_t;

  node_t nodes [NODES];

  // Leaves: one candidate per entry, padding leaves never match
  for (genvar i = 0; i < LEAFS; i++) begin : g_leaf
    if (i < ENTRIES) begin : g_real
      assign nodes[LEAFS-1+i].found = valid_i[i] && (begin_i[i] <= key_i);
      assign nodes[LEAFS-1+i].bgn   = begin_i[i];
      assign nodes[LEAFS-1+i].idx   = LV'(i);
    end else begin : g_pad
      assign nodes[LEAFS-1+i] = '0;
    end
  end

  // Inner nodes: right child replaces left only with a strictly greater begin
  for (genvar n = 0; n < LEAFS - 1; n++) begin : g_node
    logic take_right;
    assign take_right = nodes[2*n+2].found &&
                        (!nodes[2*n+1].found || (nodes[2*n+2].bgn > nodes[2*n+1].bgn));
    assign nodes[n] = take_right ? nodes[2*n+2] : nodes[2*n+1];
  end

  assign found_o = nodes[0].found;
  assign idx_o   = nodes[0].idx;

endmodule

`default_nettype wire

@@ rtl/core/ardt_table.sv @@
// Region table storage: valid bits, begin, end, offset and target per entry.
// Also finds the lowest free slot and the entry matching a begin for removal.
// Depends on ardt_pkg.
`default_nettype none

module ardt_table #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned EW      = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ardt_pkg::tbl_cmd_t      cmd_i,
  input  wire logic [$clog2(ENTRIES)-1:0] ins_idx_i,
  input  wire logic [$clog2(ENTRIES)-1:0] rem_idx_i,
  input  wire logic [EW-1:0]           new_begin_i,
  input  wire logic [EW-1:0]           new_end_i,
  input  wire logic [EW-1:0]           new_offset_i,
  input  wire logic [ardt_pkg::TARGET_W-1:0] new_target_i,
  output logic [ENTRIES-1:0]           valid_o,
  output logic [EW-1:0]                begin_o  [ENTRIES],
  output logic [EW-1:0]                end_o    [ENTRIES],
  output logic [EW-1:0]                offset_o [ENTRIES],
  output logic [ardt_pkg::TARGET_W-1:0] target_o [ENTRIES],
  output logic                         free_found_o,
  output logic [$clog2(ENTRIES)-1:0]   free_idx_o,
  output logic                         match_found_o,
  output logic [$clog2(ENTRIES)-1:0]   match_idx_o
);

  import ardt_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [ENTRIES-1:0]  valid_r;
  logic [EW-1:0]       begin_r  [ENTRIES];
  logic [EW-1:0]       end_r    [ENTRIES];
  logic [EW-1:0]       offset_r [ENTRIES];
  logic [TARGET_W-1:0] target_r [ENTRIES];

  // Valid bits: set on insert, cleared on remove
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd_i.insert) begin
        valid_r[ins_idx_i] <= 1'b1;
      end
      if (cmd_i.remove) begin
        valid_r[rem_idx_i] <= 1'b0;
      end
    end
  end

  // Region payload, meaningful only while valid
  always_ff @(posedge clk) begin
    if (cmd_i.insert) begin
      begin_r[ins_idx_i]  <= new_begin_i;
      end_r[ins_idx_i]    <= new_end_i;
      offset_r[ins_idx_i] <= new_offset_i;
      target_r[ins_idx_i] <= new_target_i;
    end
  end

  // Lowest free slot
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = IW'(i);
      end
    end
  end

  // Lowest valid entry whose begin equals the key
  always_comb begin
    match_found_o = 1'b0;
    match_idx_o   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (begin_r[i] == new_begin_i)) begin
        match_found_o = 1'b1;
        match_idx_o   = IW'(i);
      end
    end
  end

  assign valid_o  = valid_r;
  assign begin_o  = begin_r;
  assign end_o    = end_r;
  assign offset_o = offset_r;
  assign target_o = target_r;

endmodule

`default_nettype wire

@@ rtl/core/address_range_dispatch_table.sv @@
// Top level of the address range dispatch table: input stage, decision logic,
// result register. Depends on ardt_pkg, ardt_table and ardt_floor.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid / in_stall  | ardt_pkg::in_item_t
//   out_    | output    | out_valid / out_stall| ardt_pkg::out_item_t
//
// One transaction per cycle sustained while out_stall is low. An accepted
// transaction waits in the input register, moves to the result register
// (out_valid rises then) and can be taken from there.
// Table lookup, slot choice and update all happen in the cycle a transaction
// leaves the input register, so the next transaction sees the updated table.
// Synchronous active-low reset clears the valid bits and both stage valids.
// A stalled result holds a filled input register; in_stall rises only then.
`default_nettype none

module address_range_dispatch_table #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ardt_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ardt_pkg::out_item_t       out_data
);

  import ardt_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  // Addresses are masked to both the field width and ADDR_BITS
  localparam int unsigned EW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

  // Stage registers
  logic      stg_v_r;
  in_item_t  stg_r;
  logic      out_v_r;
  out_item_t out_r;
  out_item_t res_nxt;
  logic      advance;

  // Table signals
  tbl_cmd_t            cmd;
  logic [ENTRIES-1:0]  tbl_valid;
  logic [EW-1:0]       tbl_begin  [ENTRIES];
  logic [EW-1:0]       tbl_end    [ENTRIES];
  logic [EW-1:0]       tbl_offset [ENTRIES];
  logic [TARGET_W-1:0] tbl_target [ENTRIES];
  logic                free_found;
  logic [IW-1:0]       free_idx;
  logic                match_found;
  logic [IW-1:0]       match_idx;
  logic                fl_found;
  logic [IW-1:0]       fl_idx;

  // Masked fields of the transaction in the input register
  logic [EW-1:0] key;
  logic [EW-1:0] lim;
  logic [EW-1:0] off;
  logic [EW-1:0] beg_k;
  logic [EW-1:0] end_k;
  logic [EW-1:0] rebased;

  assign key = stg_r.address[EW-1:0];
  assign lim = stg_r.limit_address[EW-1:0];
  assign off = stg_r.region_offset[EW-1:0];

  // Handshake: input register moves whenever the result register can take it
  assign advance  = stg_v_r && !(out_v_r && out_stall);
  assign in_stall = stg_v_r && out_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (!in_stall) begin
      stg_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_r <= in_data;
    end
  end

  ardt_table #(
    .ENTRIES (ENTRIES),
    .EW      (EW)
  ) u_table (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .ins_idx_i     (free_idx),
    .rem_idx_i     (match_idx),
    .new_begin_i   (key),
    .new_end_i     (lim),
    .new_offset_i  (off),
    .new_target_i  (stg_r.target_id),
    .valid_o       (tbl_valid),
    .begin_o       (tbl_begin),
    .end_o         (tbl_end),
    .offset_o      (tbl_offset),
    .target_o      (tbl_target),
    .free_found_o  (free_found),
    .free_idx_o    (free_idx),
    .match_found_o (match_found),
    .match_idx_o   (match_idx)
  );

  ardt_floor #(
    .ENTRIES (ENTRIES),
    .EW      (EW)
  ) u_floor (
    .valid_i (tbl_valid),
    .begin_i (tbl_begin),
    .key_i   (key),
    .found_o (fl_found),
    .idx_o   (fl_idx)
  );

  // Selected region and rebased address
  assign beg_k   = tbl_begin[fl_idx];
  assign end_k   = tbl_end[fl_idx];
  assign rebased = key - beg_k + tbl_offset[fl_idx];

  // Decision: result fields and table update for the current transaction
  always_comb begin
    res_nxt    = '0;
    cmd.insert = 1'b0;
    cmd.remove = 1'b0;
    case (stg_r.opcode)
      OP_REGISTER: begin
        if (fl_found && (end_k >= lim)) begin
          res_nxt.status = ST_CONFLICT;
        end else if (fl_found && (beg_k == key)) begin
          res_nxt.status = ST_DUPLICATE;
        end else if (!free_found) begin
          res_nxt.status = ST_FULL;
        end else begin
          res_nxt.status = ST_DONE;
          cmd.insert     = advance;
        end
      end
      OP_UNREGISTER: begin
        if (match_found) begin
          res_nxt.status = ST_DONE;
          cmd.remove     = advance;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      OP_READ, OP_WRITE: begin
        if (fl_found && (end_k > key)) begin
          res_nxt.status         = ST_DONE;
          res_nxt.routed_target  = tbl_target[fl_idx];
          res_nxt.routed_address = ADDR_W'(rebased);
          res_nxt.routed_size    = stg_r.access_size;
          if (stg_r.opcode == OP_WRITE) begin
            res_nxt.routed_data     = stg_r.write_data;
            res_nxt.routed_is_write = 1'b1;
          end
        end else begin
          res_nxt.status = ST_UNMAPPED;
          if (stg_r.opcode == OP_READ) begin
            res_nxt.routed_data = MISS_DATA;
          end
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Checks on table bookkeeping and stage flow
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> ($countones(tbl_valid) == $past($countones(tbl_valid)) + 1))
    else $error("insert did not add exactly one valid entry");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |=> ($countones(tbl_valid) == $past($countones(tbl_valid)) - 1))
    else $error("remove did not drop exactly one valid entry");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (stg_r.opcode == OP_REGISTER) && (res_nxt.status == ST_FULL))
      |-> (&tbl_valid))
    else $error("table full reported with a free slot");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(stg_v_r))
    else $error("result appeared without a transaction in the input stage");

endmodule

`default_nettype wire
